### hdl/pinhole_camera_ray_generator_assert.svh
// concurrent assertion helpers
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define PHCAM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define PHCAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PHCAM_ASSERT(lbl, clk, rstn, prop)
`define PHCAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/phcam_pkg.sv
package phcam_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int MAG_W       = 20;
	localparam int Q_W         = 42;
	localparam int ROOT_STEPS  = 21;
	localparam int LEN_W       = 21;
	localparam int FRAC_W      = 14;
	localparam int QUO_W       = 15;
	localparam int NUM_W       = 35;
	localparam int UNIT_W      = 16;
	localparam int PROD_W      = 32;
	localparam int SUM_W       = 34;

	typedef struct packed {
		logic             sign_x;
		logic             sign_y;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
	} vec_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] z;
		logic signed [UNIT_W-1:0] y;
		logic signed [UNIT_W-1:0] x;
	} dir_t;

	typedef enum logic [2:0] {
		REG_FOV     = 3'd0,
		REG_RIGHT   = 3'd1,
		REG_UP      = 3'd2,
		REG_FORWARD = 3'd3,
		REG_ORG_XY  = 3'd4,
		REG_ORG_Z   = 3'd5
	} reg_idx_t;

	localparam logic [31:0] FOV_RESET     = 32'h1000_1000;
	localparam logic [47:0] RIGHT_RESET   = 48'h0000_0000_4000;
	localparam logic [47:0] UP_RESET      = 48'h0000_4000_0000;
	localparam logic [47:0] FORWARD_RESET = 48'h4000_0000_0000;
endpackage

### hdl/pinhole_camera_ray_generator.sv
// pinhole camera primary ray generator
// input channel: in_valid/in_ready carries one sample item (sample_u, sample_v),
//   unsigned fractions of the image plane
// output channel: out_valid/out_ready carries one ray item per sample: origin
//   (Q16.16) taken from the origin registers and a saturated Q2.14 direction
// config channel: cfg_valid/cfg_ready, cfg_index selects the register, cfg_data
//   the value; cfg_ready is always high, unknown indexes are dropped
// pipeline: 4 scale/square stages, 21 square root stages, 15 divider stages,
//   3 rotate stages, then the output buffer
// throughput: one item per cycle while in_ready is high; each root or divide
//   iteration step is its own stage so the pipeline takes a new item each clock
// a two entry output buffer holds finished items; when it is full in_ready drops
//   and the whole pipeline holds, nothing is lost or repeated
// reset: pipeline and buffer empty, registers at identity basis, unit field of
//   view and zero origin
`include "pinhole_camera_ray_generator_assert.svh"
module pinhole_camera_ray_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [phcam_pkg::SAMPLE_BITS-1:0] sample_u,
	input  logic [phcam_pkg::SAMPLE_BITS-1:0] sample_v,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                ray_origin_x,
	output logic signed [31:0]                ray_origin_y,
	output logic signed [31:0]                ray_origin_z,
	output logic signed [15:0]                ray_dir_x,
	output logic signed [15:0]                ray_dir_y,
	output logic signed [15:0]                ray_dir_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [63:0]                       cfg_data
);
	import phcam_pkg::*;

	logic [31:0] fov_q;
	logic [47:0] right_q, up_q, forward_q;
	logic [63:0] org_xy_q;
	logic [31:0] org_z_q;

	logic             en;
	logic             sc_v, rt_v, nm_v, ro_v;
	vec_t             sc_vec, rt_vec;
	logic [Q_W-1:0]   sc_q;
	logic [LEN_W-1:0] rt_len;
	logic             nm_sx, nm_sy;
	logic [QUO_W-1:0] nm_qx, nm_qy, nm_qz;
	dir_t             ro_dir;

	dir_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q     <= FOV_RESET;
			right_q   <= RIGHT_RESET;
			up_q      <= UP_RESET;
			forward_q <= FORWARD_RESET;
			org_xy_q  <= '0;
			org_z_q   <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FOV:     fov_q     <= cfg_data[31:0];
				REG_RIGHT:   right_q   <= cfg_data[47:0];
				REG_UP:      up_q      <= cfg_data[47:0];
				REG_FORWARD: forward_q <= cfg_data[47:0];
				REG_ORG_XY:  org_xy_q  <= cfg_data;
				REG_ORG_Z:   org_z_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign en       = (count_q != 2'd2);
	assign in_ready = en;

	phcam_scale u_scale (
		.clk, .arst_n, .en,
		.v_in(in_valid & en), .sample_u, .sample_v, .fov_scale(fov_q),
		.v_out(sc_v), .vec_out(sc_vec), .q_out(sc_q)
	);

	phcam_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.v_in(sc_v), .vec_in(sc_vec), .q_in(sc_q),
		.v_out(rt_v), .vec_out(rt_vec), .len_out(rt_len)
	);

	phcam_norm u_norm (
		.clk, .arst_n, .en,
		.v_in(rt_v), .vec_in(rt_vec), .len_in(rt_len),
		.v_out(nm_v), .sign_x(nm_sx), .sign_y(nm_sy),
		.quo_x(nm_qx), .quo_y(nm_qy), .quo_z(nm_qz)
	);

	phcam_rotate u_rotate (
		.clk, .arst_n, .en,
		.v_in(nm_v), .sign_x(nm_sx), .sign_y(nm_sy),
		.quo_x(nm_qx), .quo_y(nm_qy), .quo_z(nm_qz),
		.right_axis(right_q), .up_axis(up_q), .forward_axis(forward_q),
		.v_out(ro_v), .dir_out(ro_dir)
	);

	// output buffer
	assign push = en & ro_v;
	assign pop  = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ro_dir;
		end
	end

	assign out_valid    = (count_q != 2'd0);
	assign ray_dir_x    = mem_q[rd_ptr_q].x;
	assign ray_dir_y    = mem_q[rd_ptr_q].y;
	assign ray_dir_z    = mem_q[rd_ptr_q].z;
	assign ray_origin_x = org_xy_q[31:0];
	assign ray_origin_y = org_xy_q[63:32];
	assign ray_origin_z = org_z_q;

	`PHCAM_ASSERT(a_count_range, clk, arst_n, count_q != 2'd3)
	`PHCAM_ASSERT(a_no_push_full, clk, arst_n, !(ro_v && en && count_q == 2'd2))
	`PHCAM_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, count_q == $past(count_q) - 2'd1)
endmodule

### hdl/phcam_scale.sv
module phcam_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              v_in,
	input  logic [phcam_pkg::SAMPLE_BITS-1:0] sample_u,
	input  logic [phcam_pkg::SAMPLE_BITS-1:0] sample_v,
	input  logic [31:0]                       fov_scale,
	output logic                              v_out,
	output phcam_pkg::vec_t                   vec_out,
	output logic [phcam_pkg::Q_W-1:0]         q_out
);
	import phcam_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam logic [SB:0] HALF = (SB+1)'(1) << (SB-1);

	logic [SB:0]    cu, cv, au, av;
	logic           v_s1, v_s2, v_s3, v_s4;
	logic           sgn_x_s1, sgn_y_s1, sgn_x_s2, sgn_y_s2, sgn_x_s3, sgn_y_s3;
	logic [SB-1:0]  abs_x_s1, abs_y_s1;
	logic [SB+15:0] prod_x_s2, prod_y_s2;
	logic [MAG_W-1:0] mag_x_s3, mag_y_s3, mag_x;
	logic [MAG_W-1:0] mag_y;
	logic [2*MAG_W-1:0] sq_x_s3, sq_y_s3;
	vec_t           vec_s4;
	logic [Q_W-1:0] q_s4;

	assign cu = {1'b0, sample_u} - HALF;
	assign cv = {1'b0, sample_v} - HALF;
	assign au = cu[SB] ? (~cu + 1'b1) : cu;
	assign av = cv[SB] ? (~cv + 1'b1) : cv;
	assign mag_x = prod_x_s2[SB+15:SB-4];
	assign mag_y = prod_y_s2[SB+15:SB-4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_x_s1  <= cu[SB];
			sgn_y_s1  <= cv[SB];
			abs_x_s1  <= au[SB-1:0];
			abs_y_s1  <= av[SB-1:0];
			sgn_x_s2  <= sgn_x_s1;
			sgn_y_s2  <= sgn_y_s1;
			prod_x_s2 <= abs_x_s1 * fov_scale[15:0];
			prod_y_s2 <= abs_y_s1 * fov_scale[31:16];
			sgn_x_s3  <= sgn_x_s2;
			sgn_y_s3  <= sgn_y_s2;
			mag_x_s3  <= mag_x;
			mag_y_s3  <= mag_y;
			sq_x_s3   <= mag_x * mag_x;
			sq_y_s3   <= mag_y * mag_y;
			vec_s4    <= '{sign_x: sgn_x_s3, sign_y: sgn_y_s3,
				mag_x: mag_x_s3, mag_y: mag_y_s3};
			q_s4      <= Q_W'(sq_x_s3) + Q_W'(sq_y_s3) + (Q_W'(1) << 32);
		end
	end

	assign v_out   = v_s4;
	assign vec_out = vec_s4;
	assign q_out   = q_s4;
endmodule

### hdl/phcam_sqrt.sv
module phcam_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  phcam_pkg::vec_t             vec_in,
	input  logic [phcam_pkg::Q_W-1:0]   q_in,
	output logic                        v_out,
	output phcam_pkg::vec_t             vec_out,
	output logic [phcam_pkg::LEN_W-1:0] len_out
);
	import phcam_pkg::*;

	logic           v_s   [ROOT_STEPS];
	vec_t           vec_s [ROOT_STEPS];
	logic [Q_W-1:0] x_s   [ROOT_STEPS];
	logic [Q_W-1:0] res_s [ROOT_STEPS];

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		localparam logic [Q_W-1:0] BIT = Q_W'(1) << (2*(ROOT_STEPS-1-k));
		logic           v_p;
		vec_t           vec_p;
		logic [Q_W-1:0] x_p, r_p, trial;

		if (k == 0) begin : g_first
			assign v_p   = v_in;
			assign vec_p = vec_in;
			assign x_p   = q_in;
			assign r_p   = '0;
		end else begin : g_next
			assign v_p   = v_s[k-1];
			assign vec_p = vec_s[k-1];
			assign x_p   = x_s[k-1];
			assign r_p   = res_s[k-1];
		end

		assign trial = r_p + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k] <= vec_p;
				if (x_p >= trial) begin
					x_s[k]   <= x_p - trial;
					res_s[k] <= (r_p >> 1) + BIT;
				end else begin
					x_s[k]   <= x_p;
					res_s[k] <= r_p >> 1;
				end
			end
		end
	end

	assign v_out   = v_s[ROOT_STEPS-1];
	assign vec_out = vec_s[ROOT_STEPS-1];
	assign len_out = res_s[ROOT_STEPS-1][LEN_W-1:0];
endmodule

### hdl/phcam_norm.sv
module phcam_norm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  phcam_pkg::vec_t             vec_in,
	input  logic [phcam_pkg::LEN_W-1:0] len_in,
	output logic                        v_out,
	output logic                        sign_x,
	output logic                        sign_y,
	output logic [phcam_pkg::QUO_W-1:0] quo_x,
	output logic [phcam_pkg::QUO_W-1:0] quo_y,
	output logic [phcam_pkg::QUO_W-1:0] quo_z
);
	import phcam_pkg::*;

	logic             v_s   [QUO_W];
	logic             sx_s  [QUO_W];
	logic             sy_s  [QUO_W];
	logic [LEN_W-1:0] len_s [QUO_W];
	logic [NUM_W-1:0] rem_s [QUO_W][3];
	logic [QUO_W-1:0] quo_s [QUO_W][3];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int SH = QUO_W-1-k;
		logic             v_p, sx_p, sy_p;
		logic [LEN_W-1:0] len_p;
		logic [NUM_W-1:0] rem_p [3];
		logic [QUO_W-1:0] quo_p [3];
		logic [NUM_W-1:0] dvs;

		if (k == 0) begin : g_first
			assign v_p      = v_in;
			assign sx_p     = vec_in.sign_x;
			assign sy_p     = vec_in.sign_y;
			assign len_p    = len_in;
			assign rem_p[0] = NUM_W'({vec_in.mag_x, {FRAC_W{1'b0}}}) + NUM_W'(len_in >> 1);
			assign rem_p[1] = NUM_W'({vec_in.mag_y, {FRAC_W{1'b0}}}) + NUM_W'(len_in >> 1);
			assign rem_p[2] = (NUM_W'(1) << (2*FRAC_W+2)) + NUM_W'(len_in >> 1);
			assign quo_p[0] = '0;
			assign quo_p[1] = '0;
			assign quo_p[2] = '0;
		end else begin : g_next
			assign v_p   = v_s[k-1];
			assign sx_p  = sx_s[k-1];
			assign sy_p  = sy_s[k-1];
			assign len_p = len_s[k-1];
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign dvs = NUM_W'(len_p) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[k]  <= sx_p;
				sy_s[k]  <= sy_p;
				len_s[k] <= len_p;
				for (int j = 0; j < 3; j++) begin
					if (rem_p[j] >= dvs) begin
						rem_s[k][j] <= rem_p[j] - dvs;
						quo_s[k][j] <= quo_p[j] | (QUO_W'(1) << SH);
					end else begin
						rem_s[k][j] <= rem_p[j];
						quo_s[k][j] <= quo_p[j];
					end
				end
			end
		end
	end

	assign v_out  = v_s[QUO_W-1];
	assign sign_x = sx_s[QUO_W-1];
	assign sign_y = sy_s[QUO_W-1];
	assign quo_x  = quo_s[QUO_W-1][0];
	assign quo_y  = quo_s[QUO_W-1][1];
	assign quo_z  = quo_s[QUO_W-1][2];
endmodule

### hdl/phcam_rotate.sv
module phcam_rotate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic                        sign_x,
	input  logic                        sign_y,
	input  logic [phcam_pkg::QUO_W-1:0] quo_x,
	input  logic [phcam_pkg::QUO_W-1:0] quo_y,
	input  logic [phcam_pkg::QUO_W-1:0] quo_z,
	input  logic [47:0]                 right_axis,
	input  logic [47:0]                 up_axis,
	input  logic [47:0]                 forward_axis,
	output logic                        v_out,
	output phcam_pkg::dir_t             dir_out
);
	import phcam_pkg::*;

	localparam int SH_W = SUM_W - FRAC_W;

	logic signed [UNIT_W-1:0] n [3];
	logic signed [UNIT_W-1:0] m [3][3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [SUM_W-1:0]  sum_s2 [3];
	logic signed [SH_W-1:0]   sh [3];
	logic signed [UNIT_W-1:0] clip [3];
	logic                     v_s1, v_s2, v_s3;
	dir_t                     dir_s3;

	assign n[0] = sign_x ? -UNIT_W'(quo_x) : UNIT_W'(quo_x);
	assign n[1] = sign_y ? -UNIT_W'(quo_y) : UNIT_W'(quo_y);
	assign n[2] = UNIT_W'(quo_z);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m[k][0] = right_axis[16*k +: 16];
			m[k][1] = up_axis[16*k +: 16];
			m[k][2] = forward_axis[16*k +: 16];
			sh[k]   = SH_W'(sum_s2[k] >>> FRAC_W);
			if (sh[k] > SH_W'(32767)) begin
				clip[k] = 16'sh7fff;
			end else if (sh[k] < -SH_W'(32768)) begin
				clip[k] = 16'sh8000;
			end else begin
				clip[k] = sh[k][UNIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[k][j] <= m[k][j] * n[j];
				end
				sum_s2[k] <= SUM_W'(prod_s1[k][0]) + SUM_W'(prod_s1[k][1])
					+ SUM_W'(prod_s1[k][2]) + (SUM_W'(1) <<< (FRAC_W-1));
			end
			dir_s3 <= '{x: clip[0], y: clip[1], z: clip[2]};
		end
	end

	assign v_out   = v_s3;
	assign dir_out = dir_s3;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps

class ray_scoreboard;
	typedef struct {
		logic signed [31:0] org_x;
		logic signed [31:0] org_y;
		logic signed [31:0] org_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	logic [31:0] fov;
	logic [47:0] right_col;
	logic [47:0] up_col;
	logic [47:0] fwd_col;
	logic [63:0] org_xy;
	logic [31:0] org_z;
	ray_t        rays_due[$];
	int          mismatches;
	int          rays_seen;

	function new();
		fov       = phcam_pkg::FOV_RESET;
		right_col = phcam_pkg::RIGHT_RESET;
		up_col    = phcam_pkg::UP_RESET;
		fwd_col   = phcam_pkg::FORWARD_RESET;
		org_xy    = '0;
		org_z     = '0;
	endfunction

	function void write_reg(phcam_pkg::reg_idx_t idx, logic [63:0] data);
		case (idx)
			phcam_pkg::REG_FOV:     fov = data[31:0];
			phcam_pkg::REG_RIGHT:   right_col = data[47:0];
			phcam_pkg::REG_UP:      up_col = data[47:0];
			phcam_pkg::REG_FORWARD: fwd_col = data[47:0];
			phcam_pkg::REG_ORG_XY:  org_xy = data;
			phcam_pkg::REG_ORG_Z:   org_z = data[31:0];
			default: ;
		endcase
	endfunction

	function longint scaled(logic [15:0] s, logic [15:0] f);
		longint c;
		longint m;
		c = longint'(s) - 32768;
		m = ((c < 0) ? -c : c) * longint'(f);
		m = m >> 12;
		return (c < 0) ? -m : m;
	endfunction

	function longint unsigned isqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 40;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function longint unit_of(longint s, longint unsigned len);
		longint unsigned m;
		longint q;
		m = (s < 0) ? -s : s;
		q = longint'(((m << 14) + (len >> 1)) / len);
		return (s < 0) ? -q : q;
	endfunction

	function logic signed [15:0] rotate(int k, longint nx, longint ny, longint nz);
		longint sum;
		sum = longint'($signed(right_col[16*k +: 16])) * nx
			+ longint'($signed(up_col[16*k +: 16])) * ny
			+ longint'($signed(fwd_col[16*k +: 16])) * nz + 8192;
		sum = sum >>> 14;
		if (sum > 32767) sum = 32767;
		if (sum < -32768) sum = -32768;
		return sum[15:0];
	endfunction

	function void note_sample(logic [15:0] u, logic [15:0] v);
		longint sx;
		longint sy;
		longint unsigned len;
		longint nx;
		longint ny;
		longint nz;
		ray_t r;
		sx  = scaled(u, fov[15:0]);
		sy  = scaled(v, fov[31:16]);
		len = isqrt(longint'(sx * sx) + longint'(sy * sy) + (64'd1 << 32));
		if (len == 0) len = 1;
		nx = unit_of(sx, len);
		ny = unit_of(sy, len);
		nz = longint'(((64'd1 << 30) + (len >> 1)) / len);
		r.org_x = org_xy[31:0];
		r.org_y = org_xy[63:32];
		r.org_z = org_z;
		r.dir_x = rotate(0, nx, ny, nz);
		r.dir_y = rotate(1, nx, ny, nz);
		r.dir_z = rotate(2, nx, ny, nz);
		rays_due.push_back(r);
	endfunction

	function void check_ray(ray_t got);
		ray_t e;
		rays_seen++;
		if (rays_due.size() == 0) begin
			$error("unexpected ray item");
			mismatches++;
			return;
		end
		e = rays_due.pop_front();
		if (got.org_x !== e.org_x) begin
			$error("ray_origin_x expected %0d got %0d", e.org_x, got.org_x);
			mismatches++;
		end
		if (got.org_y !== e.org_y) begin
			$error("ray_origin_y expected %0d got %0d", e.org_y, got.org_y);
			mismatches++;
		end
		if (got.org_z !== e.org_z) begin
			$error("ray_origin_z expected %0d got %0d", e.org_z, got.org_z);
			mismatches++;
		end
		if (got.dir_x !== e.dir_x) begin
			$error("ray_dir_x expected %0d got %0d", e.dir_x, got.dir_x);
			mismatches++;
		end
		if (got.dir_y !== e.dir_y) begin
			$error("ray_dir_y expected %0d got %0d", e.dir_y, got.dir_y);
			mismatches++;
		end
		if (got.dir_z !== e.dir_z) begin
			$error("ray_dir_z expected %0d got %0d", e.dir_z, got.dir_z);
			mismatches++;
		end
	endfunction
endclass

module tb;
	import phcam_pkg::*;

	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 128;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        sample_u;
	logic [15:0]        sample_v;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] ray_origin_x;
	logic signed [31:0] ray_origin_y;
	logic signed [31:0] ray_origin_z;
	logic signed [15:0] ray_dir_x;
	logic signed [15:0] ray_dir_y;
	logic signed [15:0] ray_dir_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;

	ray_scoreboard sb;
	bit            idling;
	int            ready_hold;
	int            quiet_cycles;
	int            samples_sent;
	int            reg_writes;

	pinhole_camera_ray_generator dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver side stalls
	always @(posedge clk) begin
		if (!arst_n || !idling) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_ray('{ray_origin_x, ray_origin_y, ray_origin_z,
				ray_dir_x, ray_dir_y, ray_dir_z});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] u, logic [15:0] v);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_u <= u;
		sample_v <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(u, v);
		samples_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
		reg_writes++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.rays_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(16'h8000 + $urandom_range(0, 4) - 2);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [47:0] pick_axis(int phase);
		case (phase)
			2: return {3{16'h7FFF}};
			3: return {3{16'h8000}};
			default: return 48'({$urandom(), $urandom()});
		endcase
	endfunction

	initial begin
		logic [15:0] corners [5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
		sb = new();
		arst_n = 1'b0;
		idling = 1'b1;
		in_valid = 1'b0;
		sample_u = '0;
		sample_v = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers first: corners, edges and centre points of the sample square
		foreach (corners[i])
			foreach (corners[j])
				send_sample(corners[i], corners[j]);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: write_reg(REG_FOV, 64'h0);
				1: write_reg(REG_FOV, 64'hFFFF_FFFF);
				default: write_reg(REG_FOV, {$urandom(), $urandom()});
			endcase
			write_reg(REG_RIGHT, pick_axis(p));
			write_reg(REG_UP, pick_axis(p));
			write_reg(REG_FORWARD, pick_axis(p));
			if (p == 1) begin
				write_reg(REG_ORG_XY, 64'h7FFF_FFFF_8000_0000);
				write_reg(REG_ORG_Z, 64'hFFFF_FFFF_FFFF_FFFF);
			end else begin
				write_reg(REG_ORG_XY, {$urandom(), $urandom()});
				write_reg(REG_ORG_Z, {$urandom(), $urandom()});
			end
			// unknown index, must be dropped
			write_reg(reg_idx_t'($urandom_range(6, 7)), {$urandom(), $urandom()});
			if (p == RAND_PHASES - 1) idling = 1'b0;
			repeat (PHASE_ITEMS) send_sample(pick_sample(), pick_sample());
			drain();
		end

		$display("%0d samples sent over %0d register writes, %0d rays checked",
			samples_sent, reg_writes, sb.rays_seen);
		$display("field of view zero, maximum and random; basis extremes and random");
		if (sb.mismatches == 0 && sb.rays_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### files.f
+incdir+hdl
hdl/phcam_pkg.sv
hdl/phcam_scale.sv
hdl/phcam_sqrt.sv
hdl/phcam_norm.sv
hdl/phcam_rotate.sv
hdl/pinhole_camera_ray_generator.sv
bench/tb.sv
